// ===== rtl/core/bss_pkg.sv =====
`default_nettype none

package bss_pkg;

	localparam int MAX_PATTERN   = 16;
	// bytes the two pattern registers can hold between them
	localparam int PAT_REG_BYTES = 16;
	localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int POS_W         = 16;
	localparam int CFG_LEN_W     = 5;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 3;

	typedef logic [7:0] byte_t;
	typedef logic [MAX_PATTERN-1:0][7:0] window_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW,
		REG_PATTERN_HIGH,
		REG_PATTERN_LENGTH,
		REG_SEARCH_LIMIT,
		REG_IGNORE_CASE
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/bss_cfg_if.sv =====
`default_nettype none

interface bss_cfg_if import bss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bss_in_if.sv =====
`default_nettype none

interface bss_in_if import bss_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bss_out_if.sv =====
`default_nettype none

interface bss_out_if import bss_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] match_position;

	modport source(output valid, found, match_position, input ready);
	modport sink(input valid, found, match_position, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bss_window_cmp.sv =====
`default_nettype none

module bss_window_cmp import bss_pkg::*; (
	input  window_t          win,
	input  window_t          pattern,
	input  logic [LEN_W-1:0] len,
	input  logic             ignore_case,
	output logic             match
);

	function automatic byte_t fold(input byte_t b, input logic ic);
		if (ic && b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	logic [MAX_PATTERN-1:0] miss;

	// pattern byte i lines up with the window byte len-1-i places back
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
		logic [LEN_W-1:0] tap;
		assign tap     = len - LEN_W'(i + 1);
		assign miss[i] = (LEN_W'(i) < len) &&
			(fold(win[tap[IDX_W-1:0]], ignore_case) != fold(pattern[i], ignore_case));
	end

	assign match = ~|miss;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_substring_search_core.sv =====
// Bounded substring search over a byte stream.
// cfg: register writes (index, data); always ready. Registers are pattern
// low and high bytes, pattern length, search limit and case folding. Write
// them only while no string is in flight and no result is pending.
// haystack: one text byte per request with a last-byte flag. A zero byte or
// a flagged byte closes the string; the next request starts a fresh one.
// result: exactly one request per string, found plus the start position of
// the first occurrence lying wholly within the first search_limit bytes, or
// not found with position zero. Bytes after the result are swallowed.
// A byte taken from the haystack goes into the input register, is evaluated
// there, and its result loads the result register that drives result.valid.
// Throughput: one byte per cycle unless result stalls; the whole pattern is
// compared against the byte window in parallel in the single evaluation stage.
// Stall: the evaluation stage advances only when the result register is free
// or being emptied, so a stalled receiver holds the result and backs up the
// haystack channel after one buffered byte.
// Reset: clears control state and registers to their reset values at once;
// no clearing pass is needed and bytes are taken straight after reset.
`default_nettype none

module bounded_substring_search_core import bss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bss_cfg_if.sink   cfg,
	bss_in_if.sink    haystack,
	bss_out_if.source result
);

	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [CFG_LEN_W-1:0]  plen_q;
	logic [POS_W-1:0]      limit_q;
	logic                  icase_q;

	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;

	window_t          window_q;
	logic [POS_W-1:0] seen_q;
	logic             answered_q;

	logic             res_valid_s2;
	logic             found_s2;
	logic [POS_W-1:0] pos_s2;

	logic [2*CFG_DATA_W-1:0] pat_all;
	window_t                 pattern;
	window_t                 shift_win;
	logic [LEN_W-1:0]        len;
	logic [POS_W-1:0]        seen_inc;
	logic                    win_match;
	logic                    proceed;
	logic                    ends;
	logic                    emit;
	logic                    hit;
	logic                    shift;
	logic [POS_W-1:0]        pos;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			plen_q   <= '0;
			limit_q  <= '1;
			icase_q  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PATTERN_LOW:    pat_lo_q <= cfg.data;
				REG_PATTERN_HIGH:   pat_hi_q <= cfg.data;
				REG_PATTERN_LENGTH: plen_q   <= cfg.data[CFG_LEN_W-1:0];
				REG_SEARCH_LIMIT:   limit_q  <= cfg.data[POS_W-1:0];
				REG_IGNORE_CASE:    icase_q  <= cfg.data[0];
				default:            ;
			endcase
		end
	end

	assign pat_all = {pat_hi_q, pat_lo_q};

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
		if (i < PAT_REG_BYTES) begin : g_reg
			assign pattern[i] = pat_all[8*i +: 8];
		end else begin : g_zero
			assign pattern[i] = '0;
		end
	end

	assign len = (int'(plen_q) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : LEN_W'(plen_q);

	// input register
	assign proceed        = valid_s1 && (!res_valid_s2 || result.ready);
	assign haystack.ready = !valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (haystack.ready) begin
			valid_s1 <= haystack.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (haystack.valid && haystack.ready) begin
			byte_s1 <= haystack.data_byte;
			last_s1 <= haystack.last_byte;
		end
	end

	// evaluation
	assign shift_win = {window_q[MAX_PATTERN-2:0], byte_s1};
	assign seen_inc  = seen_q + POS_W'(1);
	assign ends      = last_s1 || (byte_s1 == '0);

	bss_window_cmp u_cmp (
		.win         (shift_win),
		.pattern     (pattern),
		.len         (len),
		.ignore_case (icase_q),
		.match       (win_match)
	);

	always_comb begin
		emit  = 1'b0;
		hit   = 1'b0;
		shift = 1'b0;
		pos   = '0;
		if (!answered_q) begin
			if (len == '0) begin
				// empty pattern hits on the first byte only
				emit = (seen_q == '0);
				hit  = 1'b1;
			end else if (seen_q >= limit_q || byte_s1 == '0) begin
				emit = 1'b1;
			end else begin
				shift = 1'b1;
				if (seen_inc >= POS_W'(len) && win_match) begin
					emit = 1'b1;
					hit  = 1'b1;
					pos  = seen_inc - POS_W'(len);
				end else if (seen_inc >= limit_q || last_s1) begin
					emit = 1'b1;
				end
			end
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			answered_q <= 1'b0;
		end else if (proceed) begin
			if (ends) begin
				seen_q     <= '0;
				answered_q <= 1'b0;
			end else begin
				if (shift) begin
					seen_q <= seen_inc;
				end
				if (emit) begin
					answered_q <= 1'b1;
				end
			end
		end
	end

	// stale window bytes are never compared: the count guards them
	always_ff @(posedge clk) begin
		if (proceed && shift) begin
			window_q <= shift_win;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (proceed) begin
			res_valid_s2 <= emit;
		end else if (result.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && emit) begin
			found_s2 <= hit;
			pos_s2   <= pos;
		end
	end

	assign result.valid          = res_valid_s2;
	assign result.found          = found_s2;
	assign result.match_position = pos_s2;

	a_answered_silent: assert property (@(posedge clk) disable iff (!arst_n)
		proceed && answered_q |=> !result.valid)
		else $error("result raised for a string already answered");

	a_free_takes_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> haystack.ready)
		else $error("haystack stalled with an empty result register");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proceed && ends |=> (seen_q == '0) && !answered_q)
		else $error("string state not cleared after end of string");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
	import bss_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int MAX_REPORTS   = 40;

	typedef enum int {END_ON_FLAG, END_ON_NUL, END_ON_FLAGGED_NUL} end_kind_t;

	typedef struct packed {
		byte_t value;
		logic  last;
	} hay_req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} verdict_t;

	logic clk;
	logic arst_n;

	bss_cfg_if cfg_bus();
	bss_in_if  hay_bus();
	bss_out_if res_bus();

	bounded_substring_search_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_bus),
		.haystack (hay_bus),
		.result   (res_bus)
	);

	always #5 clk = ~clk;

	// search state and registers as the block should hold them
	byte_t            win_q [MAX_PATTERN];
	logic [POS_W-1:0] seen_q;
	bit               answered_q;
	logic [63:0]      pat_lo_q;
	logic [63:0]      pat_hi_q;
	logic [4:0]       pat_len_q;
	logic [15:0]      limit_q;
	bit               fold_q;

	hay_req_t pending_bytes [$];
	verdict_t awaited_verdicts [$];
	int       sent_items;
	int       mismatches;
	int       cycle_count;

	function automatic byte_t fold_char(byte_t c);
		if (fold_q && c >= 8'h41 && c <= 8'h5A)
			return c + 8'h20;
		return c;
	endfunction

	function automatic byte_t pat_at(int i);
		if (i < 8)
			return pat_lo_q[8*i +: 8];
		if (i < PAT_REG_BYTES)
			return pat_hi_q[8*(i-8) +: 8];
		return 8'h00;
	endfunction

	function automatic int used_len();
		return (pat_len_q > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_q);
	endfunction

	function automatic bit window_hit(int len);
		int i;
		for (i = 0; i < len; i++)
			if (fold_char(win_q[len-1-i]) != fold_char(pat_at(i)))
				return 0;
		return 1;
	endfunction

	function automatic void clear_string();
		int i;
		for (i = 0; i < MAX_PATTERN; i++)
			win_q[i] = 8'h00;
		seen_q = '0;
		answered_q = 0;
	endfunction

	// advance the search by one byte; returns 1 when the byte closes the search
	function automatic bit scan_byte(byte_t b, bit last, output verdict_t v);
		int  len;
		int  i;
		bit  give;
		len = used_len();
		give = 0;
		v = '0;
		if (!answered_q) begin
			if (len == 0) begin
				if (seen_q == 0) begin
					give = 1;
					v.found = 1;
				end
			end else if (seen_q >= limit_q || b == 8'h00) begin
				give = 1;
			end else begin
				for (i = MAX_PATTERN - 1; i > 0; i--)
					win_q[i] = win_q[i-1];
				win_q[0] = b;
				seen_q = seen_q + 1'b1;
				if (seen_q >= len && window_hit(len)) begin
					give = 1;
					v.found = 1;
					v.pos = seen_q - POS_W'(len);
				end else if (seen_q >= limit_q || last) begin
					give = 1;
				end
			end
			if (give)
				answered_q = 1;
		end
		if (last || b == 8'h00)
			clear_string();
		return give;
	endfunction

	task automatic report(string msg);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// sender: bursts of requests with random gaps between them
	int       burst_left = 0;
	int       gap_left = 0;
	hay_req_t next_req;
	verdict_t new_verdict;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hay_bus.valid && hay_bus.ready)
				if (scan_byte(hay_bus.data_byte, hay_bus.last_byte, new_verdict))
					awaited_verdicts.push_back(new_verdict);
			if (!hay_bus.valid || hay_bus.ready) begin
				if (gap_left != 0 || pending_bytes.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					hay_bus.valid <= 1'b0;
				end else begin
					next_req = pending_bytes.pop_front();
					hay_bus.valid     <= 1'b1;
					hay_bus.data_byte <= next_req.value;
					hay_bus.last_byte <= next_req.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// receiver: stall pattern is redrawn at random from four modes
	int       rd_tick = 0;
	int       stall_mode = 0;
	verdict_t due;

	always @(posedge clk) begin
		if (rd_tick % 256 == 0)
			stall_mode = $urandom_range(0, 3);
		rd_tick++;
		case (stall_mode)
			0: res_bus.ready <= 1'b1;
			1: res_bus.ready <= ($urandom_range(0, 3) != 0);
			2: res_bus.ready <= 1'($urandom_range(0, 1));
			default: res_bus.ready <= (rd_tick % 16) >= 10;
		endcase
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (awaited_verdicts.size() == 0) begin
				report("result with none awaited");
			end else begin
				due = awaited_verdicts.pop_front();
				if (res_bus.found !== due.found)
					report($sformatf("found %b, want %b", res_bus.found, due.found));
				if (res_bus.match_position !== due.pos)
					report($sformatf("match_position %0d, want %0d",
						res_bus.match_position, due.pos));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t r, logic [63:0] v);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= r;
		cfg_bus.data  <= v;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (r)
			REG_PATTERN_LOW:    pat_lo_q = v;
			REG_PATTERN_HIGH:   pat_hi_q = v;
			REG_PATTERN_LENGTH: pat_len_q = v[4:0];
			REG_SEARCH_LIMIT:   limit_q = v[15:0];
			REG_IGNORE_CASE:    fold_q = v[0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
	endtask

	// unused upper bits carry junk: the block must ignore them
	task automatic apply_setup(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
			logic [15:0] limit, bit fold);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_PATTERN_LENGTH, {junk[63:5], len});
		write_reg(REG_SEARCH_LIMIT, {junk[63:16], limit});
		write_reg(REG_IGNORE_CASE, {junk[63:1], fold});
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || hay_bus.valid || awaited_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_byte(byte_t b, bit last);
		pending_bytes.push_back('{value: b, last: last});
		sent_items++;
	endtask

	task automatic send_bytes(byte_t body [$], end_kind_t k);
		int i;
		for (i = 0; i < body.size(); i++)
			queue_byte(body[i], k == END_ON_FLAG && i == body.size() - 1);
		if (k != END_ON_FLAG || body.size() == 0)
			queue_byte(8'h00, k == END_ON_FLAGGED_NUL);
	endtask

	task automatic send_text(string s, end_kind_t k);
		byte_t q [$];
		int    i;
		for (i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		send_bytes(q, k);
	endtask

	// letters around the folding range edges, to stress the case compare
	byte_t alpha [8] = '{8'h61, 8'h62, 8'h41, 8'h42, 8'h5A, 8'h7A, 8'h40, 8'h5B};

	function automatic byte_t pick_char();
		if ($urandom_range(0, 9) < 7)
			return alpha[$urandom_range(0, 7)];
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic byte_t pick_pat_char();
		int r;
		r = $urandom_range(0, 49);
		if (r == 0)
			return 8'h00;
		if (r < 5)
			return 8'($urandom_range(1, 255));
		return alpha[$urandom_range(0, 7)];
	endfunction

	initial begin
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  len;
		logic [15:0] limit;
		int          phase_goal;
		int          n;
		int          plen;
		int          p;
		int          i;
		int          r;
		byte_t       c;
		byte_t       body [$];
		byte_t       ones [$];

		clk = 0;
		arst_n = 0;
		cfg_bus.valid = 0;
		cfg_bus.index = REG_PATTERN_LOW;
		cfg_bus.data = '0;
		hay_bus.valid = 0;
		hay_bus.data_byte = '0;
		hay_bus.last_byte = 0;
		res_bus.ready = 0;
		pat_lo_q = '0;
		pat_hi_q = '0;
		pat_len_q = '0;
		limit_q = 16'hFFFF;
		fold_q = 0;
		clear_string();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset setup: empty pattern hits at position zero, zero byte included
		send_text("Q", END_ON_FLAG);
		send_text("", END_ON_NUL);
		wait_idle();

		apply_setup(64'h6241, '0, 5'd2, 16'hFFFF, 0);
		send_text("xAb", END_ON_FLAG);
		send_text("xab", END_ON_NUL);
		wait_idle();
		apply_setup(64'h6241, '0, 5'd2, 16'hFFFF, 1);
		send_text("zaB", END_ON_FLAGGED_NUL);
		wait_idle();
		// limit zero, then limit reached before the match can end
		apply_setup(64'h6241, '0, 5'd2, 16'd0, 0);
		send_text("Ab", END_ON_FLAG);
		wait_idle();
		apply_setup(64'h6241, '0, 5'd2, 16'd3, 0);
		send_text("xyAb", END_ON_FLAG);
		wait_idle();
		// oversized length clamps to the full window
		apply_setup('1, '1, 5'd31, 16'd16, 0);
		for (i = 0; i < MAX_PATTERN; i++)
			ones.push_back(8'hFF);
		send_bytes(ones, END_ON_FLAG);
		wait_idle();
		apply_setup('0, '0, 5'd0, 16'd0, 1);
		send_text("q", END_ON_FLAG);
		wait_idle();

		while (sent_items < RANDOM_ITEMS) begin
			for (i = 0; i < 8; i++) begin
				lo[8*i +: 8] = pick_pat_char();
				hi[8*i +: 8] = pick_pat_char();
			end
			if ($urandom_range(0, 9) == 0) begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end
			r = $urandom_range(0, 9);
			if (r == 0)
				len = 5'd0;
			else if (r == 1)
				len = 5'($urandom_range(17, 31));
			else if (r == 2)
				len = 5'd16;
			else
				len = 5'($urandom_range(1, 6));
			r = $urandom_range(0, 9);
			if (r < 3)
				limit = 16'hFFFF;
			else if (r == 3)
				limit = 16'd0;
			else if (r < 7)
				limit = 16'($urandom_range(1, 20));
			else if (r < 9)
				limit = 16'($urandom_range(21, 200));
			else
				limit = 16'($urandom_range(0, 65535));
			apply_setup(lo, hi, len, limit, 1'($urandom_range(0, 1)));

			plen = used_len();
			phase_goal = sent_items + $urandom_range(20, 90);
			while (sent_items < phase_goal) begin
				body.delete();
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 24);
				for (i = 0; i < n; i++)
					body.push_back(pick_char());
				// plant an occurrence, with random case where folding is on
				if (plen > 0 && plen <= n && $urandom_range(0, 2) != 0) begin
					p = $urandom_range(0, n - plen);
					for (i = 0; i < plen; i++) begin
						c = pat_at(i);
						if (fold_q && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A
								&& $urandom_range(0, 1))
							c = c ^ 8'h20;
						body[p+i] = c;
					end
				end
				if (n > 2 && $urandom_range(0, 29) == 0)
					body[$urandom_range(0, n - 1)] = 8'h00;
				r = $urandom_range(0, 3);
				if (r < 2)
					send_bytes(body, END_ON_FLAG);
				else if (r == 2)
					send_bytes(body, END_ON_NUL);
				else
					send_bytes(body, END_ON_FLAGGED_NUL);
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
